/* rtl/lr_pkg.sv */
// Shared types and constants for the line rasterizer.
// Holds the request, pixel and job structs used by every rtl module.
// No dependencies.
package lr_pkg;

	// Coordinate width and the derived width of the signed decision term.
	localparam int COORD_BITS = 6;
	localparam int TERM_BITS  = COORD_BITS + 3;

	// Job queue between the setup front end and the walker.
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COORD_BITS-1:0]       coord_t;
	typedef logic signed [TERM_BITS-1:0] term_t;

	// One request: the two endpoints of a line.
	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} req_t;

	// One result: a pixel of the line.
	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   last_pixel;
	} pix_t;

	// A classified line, ready to be walked.
	typedef struct packed {
		coord_t maj;
		coord_t mnr;
		coord_t dmaj;
		coord_t dmin;
		term_t  term;
		logic   dir_neg;
		logic   x_major;
	} job_t;

endpackage

/* rtl/lr_front.sv */
// Setup front end of the line rasterizer.
// Takes requests, works out major axis, deltas, start point and first decision term.
// Depends on lr_pkg.
module lr_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  lr_pkg::req_t req_data,
	output logic         job_valid,
	input  logic         job_ready,
	output lr_pkg::job_t job_data
);
	import lr_pkg::*;

	logic   x_back;
	logic   y_back;
	logic   dx_nz;
	logic   dy_nz;
	coord_t adx;
	coord_t ady;
	job_t   job_d;
	job_t   job_s1;
	logic   job_valid_s1;
	logic   accept;

	// Classify the line: deltas, slope sign, major axis and start endpoint.
	always_comb begin
		x_back = req_data.end_x < req_data.start_x;
		y_back = req_data.end_y < req_data.start_y;
		dx_nz  = req_data.end_x != req_data.start_x;
		dy_nz  = req_data.end_y != req_data.start_y;
		adx    = x_back ? (req_data.start_x - req_data.end_x) : (req_data.end_x - req_data.start_x);
		ady    = y_back ? (req_data.start_y - req_data.end_y) : (req_data.end_y - req_data.start_y);

		job_d.x_major = adx >= ady;
		job_d.dir_neg = dx_nz && dy_nz && (x_back != y_back);
		if (job_d.x_major) begin
			job_d.dmaj = adx;
			job_d.dmin = ady;
			job_d.maj  = x_back ? req_data.end_x : req_data.start_x;
			job_d.mnr  = x_back ? req_data.end_y : req_data.start_y;
		end else begin
			job_d.dmaj = ady;
			job_d.dmin = adx;
			job_d.maj  = y_back ? req_data.end_y : req_data.start_y;
			job_d.mnr  = y_back ? req_data.end_x : req_data.start_x;
		end
		// Initial decision term is 2*minor - major.
		job_d.term = $signed({2'b00, job_d.dmin, 1'b0}) - $signed({3'b000, job_d.dmaj});
	end

	// The stage takes a new request whenever it is empty or hands its job on.
	assign req_stall = job_valid_s1 && !job_ready;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (accept) begin
			job_valid_s1 <= 1'b1;
		end else if (job_ready) begin
			job_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
		end
	end

	assign job_valid = job_valid_s1;
	assign job_data  = job_s1;

endmodule

/* rtl/lr_queue.sv */
// Short job queue that decouples the setup front end from the walker.
// Register-based, QUEUE_DEPTH entries, first in first out.
// Depends on lr_pkg.
module lr_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  lr_pkg::job_t push_data,
	output logic         pop_valid,
	input  logic         pop_take,
	output lr_pkg::job_t pop_data
);
	import lr_pkg::*;

	typedef logic [QUEUE_IDX_BITS-1:0] qidx_t;
	typedef logic [QUEUE_CNT_BITS-1:0] qcnt_t;

	job_t  entry_q [QUEUE_DEPTH];
	qidx_t wr_ptr_q;
	qidx_t rd_ptr_q;
	qcnt_t count_q;
	logic  push;
	logic  pop;

	function automatic qidx_t next_idx(input qidx_t idx);
		next_idx = (idx == qidx_t'(QUEUE_DEPTH - 1)) ? '0 : idx + qidx_t'(1);
	endfunction

	assign push_ready = count_q != qcnt_t'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_take && pop_valid;
	assign pop_data   = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_idx(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_idx(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + qcnt_t'(1);
			end else if (pop && !push) begin
				count_q <= count_q - qcnt_t'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/lr_back.sv */
// Walker of the line rasterizer: steps along the major axis, one pixel a cycle while pix_stall is low.
// Takes jobs from the queue and drives the registered pixel output.
// Depends on lr_pkg.
module lr_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	output logic         job_take,
	input  lr_pkg::job_t job_data,
	output logic         pix_valid,
	input  logic         pix_stall,
	output lr_pkg::pix_t pix_data
);
	import lr_pkg::*;

	logic   busy_q;
	logic   pix_valid_q;
	pix_t   pix_q;
	coord_t maj_q;
	coord_t mnr_q;
	coord_t cnt_q;
	coord_t dmaj_q;
	coord_t dmin_q;
	term_t  term_q;
	logic   dir_neg_q;
	logic   x_major_q;
	logic   advance;
	logic   last;
	term_t  dmin2;
	term_t  dmaj2;

	// A new job is loaded only when the walker is free.
	assign job_take = !busy_q && job_valid;
	// A pixel is produced when the output register is empty or being drained.
	assign advance  = busy_q && (!pix_valid_q || !pix_stall);
	assign last     = cnt_q == '0;
	assign dmin2    = $signed({2'b00, dmin_q, 1'b0});
	assign dmaj2    = $signed({2'b00, dmaj_q, 1'b0});

	// Control: walker busy flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (job_take) begin
				busy_q <= 1'b1;
			end else if (advance && last) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	// Walk state and output pixel.
	always_ff @(posedge clk) begin
		if (job_take) begin
			maj_q     <= job_data.maj;
			mnr_q     <= job_data.mnr;
			cnt_q     <= job_data.dmaj;
			dmaj_q    <= job_data.dmaj;
			dmin_q    <= job_data.dmin;
			term_q    <= job_data.term;
			dir_neg_q <= job_data.dir_neg;
			x_major_q <= job_data.x_major;
		end else if (advance) begin
			pix_q.pixel_x    <= x_major_q ? maj_q : mnr_q;
			pix_q.pixel_y    <= x_major_q ? mnr_q : maj_q;
			pix_q.last_pixel <= last;
			if (!last) begin
				cnt_q <= cnt_q - coord_t'(1);
				maj_q <= maj_q + coord_t'(1);
				if (term_q[TERM_BITS-1]) begin
					term_q <= term_q + dmin2;
				end else begin
					mnr_q  <= dir_neg_q ? (mnr_q - coord_t'(1)) : (mnr_q + coord_t'(1));
					term_q <= term_q + dmin2 - dmaj2;
				end
			end
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix_data  = pix_q;

endmodule

/* rtl/line_rasterizer_top.sv */
// Line rasterizer: turns a pair of endpoints into the pixels of a Bresenham line.
// One request carries start_x, start_y, end_x, end_y on req_data; it is taken at
// a clock edge where req_valid is high and req_stall is low.
// Each pixel leaves on pix_data (pixel_x, pixel_y, last_pixel) and is taken at an
// edge where pix_valid is high and pix_stall is low. last_pixel marks the end of
// a line; equal endpoints give a single pixel with last_pixel set.
// The request passes through the setup register and the job queue, is loaded into
// the walker, and its first pixel is then registered in the output register. The
// walker emits one pixel per cycle while pix_stall is low; a line with major
// delta D gives D + 1 pixels, up to 64 at 6-bit coordinates. A setup stage and a
// two-entry job queue let up to three further requests be taken while a line is being walked.
// While pix_stall is high the pixel register holds its value and the walker
// pauses; once the queue and the setup stage are both full, req_stall rises.
// arst_n clears all valid flags, the queue and the walker at once; no clearing
// pass follows reset.
// Depends on lr_pkg, lr_front, lr_queue and lr_back.
module line_rasterizer_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  lr_pkg::req_t req_data,
	output logic         pix_valid,
	input  logic         pix_stall,
	output lr_pkg::pix_t pix_data
);
	import lr_pkg::*;

	logic front_valid;
	logic front_ready;
	job_t front_job;
	logic queue_valid;
	logic queue_take;
	job_t queue_job;

	// Setup stage.
	lr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.job_data  (front_job)
	);

	// Job queue.
	lr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_job),
		.pop_valid  (queue_valid),
		.pop_take   (queue_take),
		.pop_data   (queue_job)
	);

	// Walker and output register.
	lr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_valid),
		.job_take  (queue_take),
		.job_data  (queue_job),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data)
	);

endmodule

/* rtl/lr_checker.sv */
// Port-level checks for the line rasterizer, bound to line_rasterizer_top.
// Tracks open lines and the previous pixel of the current line.
// Depends on lr_pkg.
module lr_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         req_valid,
	input logic         req_stall,
	input logic         pix_valid,
	input logic         pix_stall,
	input lr_pkg::pix_t pix_data
);
	import lr_pkg::*;

	logic       req_acc;
	logic       pix_acc;
	logic [3:0] open_q;
	logic       mid_line_q;
	coord_t     prev_x_q;
	coord_t     prev_y_q;
	logic       step_x;
	logic       step_y;
	logic       same_x;
	logic       same_y;

	assign req_acc = req_valid && !req_stall;
	assign pix_acc = pix_valid && !pix_stall;

	// Count of requests whose last pixel has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= '0;
			mid_line_q <= 1'b0;
		end else begin
			if (req_acc && !(pix_acc && pix_data.last_pixel)) begin
				open_q <= open_q + 4'd1;
			end else if (!req_acc && pix_acc && pix_data.last_pixel) begin
				open_q <= open_q - 4'd1;
			end
			if (pix_acc) begin
				mid_line_q <= !pix_data.last_pixel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			prev_x_q <= pix_data.pixel_x;
			prev_y_q <= pix_data.pixel_y;
		end
	end

	// Neighborhood of the previous pixel.
	always_comb begin
		same_x = pix_data.pixel_x == prev_x_q;
		same_y = pix_data.pixel_y == prev_y_q;
		step_x = same_x || (pix_data.pixel_x == prev_x_q + coord_t'(1)) ||
			(pix_data.pixel_x == prev_x_q - coord_t'(1));
		step_y = same_y || (pix_data.pixel_y == prev_y_q + coord_t'(1)) ||
			(pix_data.pixel_y == prev_y_q - coord_t'(1));
	end

	// A stalled pixel stays valid and unchanged.
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix_data))
		else $error("pixel changed while stalled");

	// Pixels only appear for a line that was requested.
	a_pix_owned: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> open_q != '0)
		else $error("pixel without an open line");

	// No more lines are open than the setup stage, queue, walker and the
	// stalled last pixel in the output register can hold.
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 4'(QUEUE_DEPTH + 3))
		else $error("too many open lines");

	// Consecutive pixels of one line are distinct 8-connected neighbors.
	a_pix_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && mid_line_q |-> step_x && step_y && !(same_x && same_y))
		else $error("line pixels not adjacent");

endmodule

bind line_rasterizer_top lr_checker u_lr_checker (.*);
